@@ design/clock_divider_register_encoder_defines.svh @@
// Assertion macros shared by the divider register encoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CLOCK_DIVIDER_REGISTER_ENCODER_DEFINES_SVH
`define CLOCK_DIVIDER_REGISTER_ENCODER_DEFINES_SVH

// same-cycle implication
`define CDRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cdre_pkg.sv @@
// Types, constants and microcode program of the divider register encoder.
// No dependencies.
`default_nettype none

package cdre_pkg;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CHECK,
    OP_DIV,
    OP_P1,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef enum logic [2:0] {
    JC_ALWAYS,  // go to target
    JC_IN,      // go to target on input transfer, else hold
    JC_ERR,     // go to target on check failure, else next step
    JC_DIV,     // hold until last divide iteration, then next step
    JC_OUT      // go to target once the output slot takes the byte
  } jc_e;

  localparam int unsigned PcW = 4;

  typedef struct packed {
    op_e            op;
    logic [3:0]     sel;
    jc_e            jc;
    logic [PcW-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic err;
    logic div_last;
    logic out_free;
  } stat_t;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrNotReady = 2'd1;
  localparam logic [1:0] ErrParam    = 2'd2;

  localparam logic [7:0] PllBaseA     = 8'd26;
  localparam logic [7:0] PllBaseB     = 8'd34;
  localparam logic [7:0] MsBase       = 8'd42;
  localparam logic [7:0] PllResetAddr = 8'd177;
  localparam logic [7:0] PllResetData = 8'hA0;
  localparam logic [7:0] ClkCtrlBase  = 8'd16;
  localparam logic [7:0] ClkCtrlBits  = 8'h0F;

  localparam logic [3:0] SelCtrl = 4'd8;  // ninth write: PLL reset or output control

  localparam logic [PcW-1:0] StIdle  = 4'd0;
  localparam logic [PcW-1:0] StCheck = 4'd1;
  localparam logic [PcW-1:0] StDiv   = 4'd2;
  localparam logic [PcW-1:0] StP1    = 4'd3;
  localparam logic [PcW-1:0] StEmit0 = 4'd4;
  localparam logic [PcW-1:0] StErr   = 4'd13;

  function automatic ctl_t rom(input logic [PcW-1:0] pc);
    ctl_t w;
    w = '{op: OP_IDLE, sel: 4'd0, jc: JC_ALWAYS, target: StIdle};
    unique case (pc)
      StIdle:  w = '{op: OP_IDLE,  sel: 4'd0, jc: JC_IN,     target: StCheck};
      StCheck: w = '{op: OP_CHECK, sel: 4'd0, jc: JC_ERR,    target: StErr};
      StDiv:   w = '{op: OP_DIV,   sel: 4'd0, jc: JC_DIV,    target: StP1};
      StP1:    w = '{op: OP_P1,    sel: 4'd0, jc: JC_ALWAYS, target: StEmit0};
      4'd4:    w = '{op: OP_EMIT,  sel: 4'd0, jc: JC_OUT,    target: 4'd5};
      4'd5:    w = '{op: OP_EMIT,  sel: 4'd1, jc: JC_OUT,    target: 4'd6};
      4'd6:    w = '{op: OP_EMIT,  sel: 4'd2, jc: JC_OUT,    target: 4'd7};
      4'd7:    w = '{op: OP_EMIT,  sel: 4'd3, jc: JC_OUT,    target: 4'd8};
      4'd8:    w = '{op: OP_EMIT,  sel: 4'd4, jc: JC_OUT,    target: 4'd9};
      4'd9:    w = '{op: OP_EMIT,  sel: 4'd5, jc: JC_OUT,    target: 4'd10};
      4'd10:   w = '{op: OP_EMIT,  sel: 4'd6, jc: JC_OUT,    target: 4'd11};
      4'd11:   w = '{op: OP_EMIT,  sel: 4'd7, jc: JC_OUT,    target: 4'd12};
      4'd12:   w = '{op: OP_EMIT,  sel: SelCtrl, jc: JC_OUT, target: StIdle};
      StErr:   w = '{op: OP_ERR,   sel: 4'd0, jc: JC_OUT,    target: StIdle};
      default: w = '{op: OP_IDLE,  sel: 4'd0, jc: JC_ALWAYS, target: StIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/cdre_seq.sv @@
// Microcode sequencer: step counter, program ROM and branch logic.
// Depends on cdre_pkg.
`default_nettype none

module cdre_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  cdre_pkg::stat_t    stat_i,
  output cdre_pkg::ctl_t     ctl_o
);

  logic [cdre_pkg::PcW-1:0] pc_q, pc_d;
  cdre_pkg::ctl_t           ctl;

  assign ctl   = cdre_pkg::rom(pc_q);
  assign ctl_o = ctl;

  always_comb begin
    pc_d = pc_q;
    unique case (ctl.jc)
      cdre_pkg::JC_ALWAYS: pc_d = ctl.target;
      cdre_pkg::JC_IN:     if (in_valid_i) pc_d = ctl.target;
      cdre_pkg::JC_ERR:    pc_d = stat_i.err ? ctl.target : pc_q + 1'b1;
      cdre_pkg::JC_DIV:    if (stat_i.div_last) pc_d = pc_q + 1'b1;
      cdre_pkg::JC_OUT:    if (stat_i.out_free) pc_d = ctl.target;
      default:             pc_d = cdre_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cdre_pkg::StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ design/cdre_dp.sv @@
// Datapath: request registers, checks, bit-serial divider, P1/P2/P3 and
// the output byte register. Driven by the control word from cdre_seq.
`default_nettype none

module cdre_dp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  cdre_pkg::ctl_t    ctl_i,
  input  wire logic         in_xfer_i,
  input  wire logic         func_i,
  input  wire logic         pll_select_i,
  input  wire logic [1:0]   output_channel_i,
  input  wire logic [9:0]   int_part_i,
  input  wire logic [19:0]  numerator_i,
  input  wire logic [19:0]  denominator_i,
  input  wire logic         cfg_xfer_i,
  input  wire logic         cfg_data_i,
  input  wire logic         out_ready_i,
  output cdre_pkg::stat_t   stat_o,
  output logic              out_valid_o,
  output logic [7:0]        reg_addr_o,
  output logic [7:0]        reg_data_o,
  output logic [1:0]        error_o,
  output logic              last_o
);

  localparam int unsigned QW = 27;  // width of 128*b

  logic        func_q, pll_q;
  logic [1:0]  chan_q;
  logic [9:0]  a_q;
  logic [19:0] b_q, c_q;
  logic [1:0]  err_q, chk_code;
  logic        dev_ready_q, pll_a_cfg_q, pll_b_cfg_q, src_cfg;

  logic [QW-1:0] qn_q;    // dividend bits shift out, quotient bits shift in
  logic [19:0]   rem_q;
  logic [4:0]    cnt_q;
  logic [20:0]   rem_sh, trial;
  logic [17:0]   p1_q;

  logic        out_valid_q, out_last_q, out_free;
  logic [7:0]  out_addr_q, out_data_q, base, byte_addr, byte_data;
  logic [1:0]  out_err_q;

  assign src_cfg = pll_q ? pll_b_cfg_q : pll_a_cfg_q;

  always_comb begin
    chk_code = cdre_pkg::ErrNone;
    if (!dev_ready_q) begin
      chk_code = cdre_pkg::ErrNotReady;
    end else if (!func_q) begin
      if (a_q < 10'd15 || a_q > 10'd90 || c_q == 20'd0) chk_code = cdre_pkg::ErrParam;
    end else begin
      if (chan_q == 2'd3 || a_q < 10'd4 || a_q > 10'd900 || c_q == 20'd0 || !src_cfg) begin
        chk_code = cdre_pkg::ErrParam;
      end
    end
  end

  assign rem_sh = {rem_q, qn_q[QW-1]};
  assign trial  = rem_sh - {1'b0, c_q};

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.err      = (chk_code != cdre_pkg::ErrNone);
  assign stat_o.div_last = (cnt_q == 5'd0);
  assign stat_o.out_free = out_free;

  assign base = func_q ? cdre_pkg::MsBase + {3'd0, chan_q, 3'd0}
                       : (pll_q ? cdre_pkg::PllBaseB : cdre_pkg::PllBaseA);

  // P3 = c, P2 = remainder of 128*b / c
  always_comb begin
    byte_addr = base + {4'd0, ctl_i.sel};
    byte_data = 8'd0;
    unique case (ctl_i.sel)
      4'd0: byte_data = c_q[15:8];
      4'd1: byte_data = c_q[7:0];
      4'd2: byte_data = {6'd0, p1_q[17:16]};
      4'd3: byte_data = p1_q[15:8];
      4'd4: byte_data = p1_q[7:0];
      4'd5: byte_data = {c_q[19:16], rem_q[19:16]};
      4'd6: byte_data = rem_q[15:8];
      4'd7: byte_data = rem_q[7:0];
      cdre_pkg::SelCtrl: begin
        if (!func_q) begin
          byte_addr = cdre_pkg::PllResetAddr;
          byte_data = cdre_pkg::PllResetData;
        end else begin
          byte_addr = cdre_pkg::ClkCtrlBase + {6'd0, chan_q};
          byte_data = cdre_pkg::ClkCtrlBits | {1'b0, b_q == 20'd0, pll_q, 5'd0};
        end
      end
      default: byte_data = 8'd0;
    endcase
  end

  // request and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      func_q <= func_i;
      pll_q  <= pll_select_i;
      chan_q <= output_channel_i;
      a_q    <= int_part_i;
      b_q    <= numerator_i;
      c_q    <= denominator_i;
    end
    unique case (ctl_i.op)
      cdre_pkg::OP_CHECK: begin
        err_q <= chk_code;
        rem_q <= 20'd0;
        qn_q  <= {b_q, 7'd0};
        cnt_q <= 5'(QW - 1);
      end
      cdre_pkg::OP_DIV: begin
        if (!trial[20]) begin
          rem_q <= trial[19:0];
          qn_q  <= {qn_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[19:0];
          qn_q  <= {qn_q[QW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 5'd1;
      end
      cdre_pkg::OP_P1: p1_q <= {1'b0, a_q, 7'd0} + qn_q[17:0] - 18'd512;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_ready_q <= 1'b0;
      pll_a_cfg_q <= 1'b0;
      pll_b_cfg_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_xfer_i) begin
        dev_ready_q <= cfg_data_i;
        pll_a_cfg_q <= 1'b0;
        pll_b_cfg_q <= 1'b0;
      end else if (ctl_i.op == cdre_pkg::OP_EMIT && ctl_i.sel == cdre_pkg::SelCtrl &&
                   out_free && !func_q) begin
        if (pll_q) pll_b_cfg_q <= 1'b1;
        else       pll_a_cfg_q <= 1'b1;
      end
      if (out_free && (ctl_i.op == cdre_pkg::OP_EMIT || ctl_i.op == cdre_pkg::OP_ERR)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && ctl_i.op == cdre_pkg::OP_EMIT) begin
      out_addr_q <= byte_addr;
      out_data_q <= byte_data;
      out_err_q  <= cdre_pkg::ErrNone;
      out_last_q <= (ctl_i.sel == cdre_pkg::SelCtrl);
    end else if (out_free && ctl_i.op == cdre_pkg::OP_ERR) begin
      out_addr_q <= 8'd0;
      out_data_q <= 8'd0;
      out_err_q  <= err_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_addr_o  = out_addr_q;
  assign reg_data_o  = out_data_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

@@ design/clock_divider_register_encoder.sv @@
// Top level of the fractional divider register encoder.
// Depends on cdre_pkg, cdre_seq, cdre_dp and the assertion macro header.
//
//  channel   direction  tdata / data                              tuser / last
//  s_axis    in         [1:0] chan [11:2] a [31:12] b [51:32] c   [0] func [1] pll
//  m_axis    out        [7:0] reg_addr [15:8] reg_data            [1:0] error, tlast
//  cfg       in         [0] device_ready                          -
//
// One request at a time. A good request passes the check, the bit-serial divide,
// the P1 step and nine byte steps, up to its last byte; a failed check goes to
// the error step. An output stall holds the sequencer in its current output step.
// Reset clears the sequencer, the output valid, device_ready and both PLL flags.
// s_axis_tready is high only while the sequencer sits in its idle step.
`default_nettype none

`include "clock_divider_register_encoder_defines.svh"

module clock_divider_register_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // chan[1:0], int_part, numerator, denominator
  input  wire logic [1:0]  s_axis_tuser,   // func, pll_select
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // reg_addr, reg_data
  output logic [1:0]       m_axis_tuser,   // error
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i      // device_ready
);

  cdre_pkg::ctl_t  ctl;
  cdre_pkg::stat_t stat;
  logic            in_xfer;

  assign s_axis_tready = (ctl.op == cdre_pkg::OP_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  cdre_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  cdre_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .in_xfer_i        (in_xfer),
    .func_i           (s_axis_tuser[0]),
    .pll_select_i     (s_axis_tuser[1]),
    .output_channel_i (s_axis_tdata[1:0]),
    .int_part_i       (s_axis_tdata[11:2]),
    .numerator_i      (s_axis_tdata[31:12]),
    .denominator_i    (s_axis_tdata[51:32]),
    .cfg_xfer_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (m_axis_tready),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid),
    .reg_addr_o       (m_axis_tdata[7:0]),
    .reg_data_o       (m_axis_tdata[15:8]),
    .error_o          (m_axis_tuser),
    .last_o           (m_axis_tlast)
  );

  `CDRE_ASSERT_NXT(a_leave_idle, in_xfer, !s_axis_tready, "sequencer stayed idle after transfer")
  `CDRE_ASSERT_NOW(a_err_last, m_axis_tvalid && m_axis_tuser != 2'd0, m_axis_tlast,
                   "error result without last")
  `CDRE_ASSERT_NXT(a_div_hold, ctl.op == cdre_pkg::OP_DIV && !stat.div_last,
                   ctl.op == cdre_pkg::OP_DIV, "divide left before last iteration")

endmodule

`default_nettype wire
